// ===== rtl/recent_string_prefix_delta_assert.svh =====
// Assertion macros for the recent_string_prefix_delta RTL.
// Include by bare file name; depends on nothing else.
`ifndef RECENT_STRING_PREFIX_DELTA_ASSERT_SVH
`define RECENT_STRING_PREFIX_DELTA_ASSERT_SVH

`ifndef SYNTHESIS
// Clocked check, off while reset is asserted.
`define RSPD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also holds during reset.
`define RSPD_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RSPD_ASSERT(lbl, clk, rst_n, prop, msg)
`define RSPD_ASSERT_NR(lbl, clk, prop, msg)
`endif

`endif

// ===== rtl/rspd_pkg.sv =====
// Package for recent_string_prefix_delta: sizes, codes and shared types.
// No dependencies; every RTL module of the block imports it.
package rspd_pkg;

  localparam int DICT_DEPTH = 8;
  localparam int MAX_LEN    = 32;

  localparam int SLOT_W = (DICT_DEPTH > 1) ? $clog2(DICT_DEPTH) : 1;
  localparam int POS_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int LEN_W  = $clog2(MAX_LEN + 1);

  localparam int BYTE_W     = 8;
  localparam int MIN_W      = 6;
  localparam int CAP_W      = 8;
  localparam int PLEN_W     = 6;
  localparam int IDX_W      = 3;
  localparam int OUT_DATA_W = 24;
  localparam int APB_AW     = 3;
  localparam int APB_DW     = 32;

  localparam logic [MIN_W-1:0] MIN_MATCH_RST = 6'd5;
  localparam logic [CAP_W-1:0] MATCH_CAP_RST = 8'd129;

  // Register select (paddr bit 2).
  localparam logic REG_MIN_MATCH = 1'b0;
  localparam logic REG_MATCH_CAP = 1'b1;

  // Result beat kinds.
  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_SUFFIX = 1'b1;

  // Control from the sequencer to the per-slot match lanes.
  typedef struct packed {
    logic              clear;   // restart prefix tracking for a new string
    logic              step;    // fold one byte into every lane
    logic              commit;  // store pos as the length of the oldest slot
    logic [BYTE_W-1:0] byte_val;
    logic [LEN_W-1:0]  pos;
    logic [SLOT_W-1:0] oldest;
  } match_ctrl_t;

endpackage

// ===== rtl/rspd_apb_regs.sv =====
// APB register file for recent_string_prefix_delta: min_match and match_cap.
// Depends on rspd_pkg.
module rspd_apb_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rspd_pkg::APB_AW-1:0] paddr,
  input  logic [rspd_pkg::APB_DW-1:0] pwdata,
  output logic [rspd_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  output logic [rspd_pkg::MIN_W-1:0]  min_match_o,
  output logic [rspd_pkg::CAP_W-1:0]  match_cap_o
);
  import rspd_pkg::*;

  logic [MIN_W-1:0] min_match_q;
  logic [CAP_W-1:0] match_cap_q;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_match_q <= MIN_MATCH_RST;
      match_cap_q <= MATCH_CAP_RST;
    end else if (wr_en) begin
      case (paddr[2])
        REG_MIN_MATCH: min_match_q <= pwdata[MIN_W-1:0];
        REG_MATCH_CAP: match_cap_q <= pwdata[CAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_MIN_MATCH: prdata = APB_DW'(min_match_q);
      REG_MATCH_CAP: prdata = APB_DW'(match_cap_q);
      default:       prdata = '0;
    endcase
  end

  assign min_match_o = min_match_q;
  assign match_cap_o = match_cap_q;

endmodule

// ===== rtl/rspd_window_ram.sv =====
// Window string store: one row per byte position, one byte lane per slot.
// Depends on rspd_pkg. Synchronous read with a registered output; byte-lane write.
module rspd_window_ram (
  input  logic                                             clk_i,
  input  logic                                             re_i,
  input  logic [rspd_pkg::POS_W-1:0]                       raddr_i,
  output logic [rspd_pkg::DICT_DEPTH-1:0][rspd_pkg::BYTE_W-1:0] rdata_o,
  input  logic                                             we_i,
  input  logic [rspd_pkg::POS_W-1:0]                       waddr_i,
  input  logic [rspd_pkg::SLOT_W-1:0]                      wlane_i,
  input  logic [rspd_pkg::BYTE_W-1:0]                      wdata_i
);
  import rspd_pkg::*;

  logic [DICT_DEPTH-1:0][BYTE_W-1:0] mem_q [MAX_LEN];
  logic [DICT_DEPTH-1:0][BYTE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i][wlane_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/rspd_string_buf.sv =====
// Buffer for the bytes of the string being received.
// Depends on rspd_pkg. Synchronous read with a registered output.
module rspd_string_buf (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [rspd_pkg::POS_W-1:0]  waddr_i,
  input  logic [rspd_pkg::BYTE_W-1:0] wdata_i,
  input  logic                        re_i,
  input  logic [rspd_pkg::POS_W-1:0]  raddr_i,
  output logic [rspd_pkg::BYTE_W-1:0] rdata_o
);
  import rspd_pkg::*;

  logic [BYTE_W-1:0] mem_q [MAX_LEN];
  logic [BYTE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/rspd_match_lanes.sv =====
// Per-slot prefix trackers, stored slot lengths and the best-entry search.
// Depends on rspd_pkg.
module rspd_match_lanes (
  input  logic                                             clk_i,
  input  logic                                             rst_ni,
  input  rspd_pkg::match_ctrl_t                            ctrl_i,
  input  logic [rspd_pkg::CAP_W-1:0]                       match_cap_i,
  input  logic [rspd_pkg::DICT_DEPTH-1:0][rspd_pkg::BYTE_W-1:0] row_i,
  output logic [rspd_pkg::LEN_W-1:0]                       best_len_o,
  output logic [rspd_pkg::SLOT_W-1:0]                      best_slot_o
);
  import rspd_pkg::*;

  logic [LEN_W-1:0]      prefix_q [DICT_DEPTH];
  logic [LEN_W-1:0]      prefix_d [DICT_DEPTH];
  logic [LEN_W-1:0]      wlen_q   [DICT_DEPTH];
  logic [LEN_W-1:0]      wlen_d   [DICT_DEPTH];
  logic [DICT_DEPTH-1:0] still_q, still_d;
  logic [LEN_W-1:0]      best_len_q, best_len_d;
  logic [SLOT_W-1:0]     best_slot_q, best_slot_d;

  // Lane update: one compare per slot against the row of the current position.
  always_comb begin
    for (int s = 0; s < DICT_DEPTH; s++) begin
      prefix_d[s] = prefix_q[s];
      still_d[s]  = still_q[s];
      wlen_d[s]   = wlen_q[s];
      if (ctrl_i.clear) begin
        prefix_d[s] = '0;
        still_d[s]  = 1'b1;
      end else if (ctrl_i.step) begin
        if (still_q[s] && (ctrl_i.pos < wlen_q[s]) && (row_i[s] == ctrl_i.byte_val) &&
            (CAP_W'(prefix_q[s]) < match_cap_i)) begin
          prefix_d[s] = prefix_q[s] + LEN_W'(1);
        end else begin
          still_d[s] = 1'b0;
        end
      end
      if (ctrl_i.commit && (ctrl_i.oldest == SLOT_W'(s))) begin
        wlen_d[s] = ctrl_i.pos;
      end
    end
  end

  // Longest prefix wins; among equals the entry with the highest age rank
  // (newest) wins. A zero prefix never matches.
  always_comb begin
    logic [SLOT_W:0] rank;
    best_len_d  = '0;
    best_slot_d = '0;
    for (int s = 0; s < DICT_DEPTH; s++) begin
      if (SLOT_W'(s) >= ctrl_i.oldest) begin
        rank = (SLOT_W+1)'(s) - {1'b0, ctrl_i.oldest};
      end else begin
        rank = (SLOT_W+1)'(s + DICT_DEPTH) - {1'b0, ctrl_i.oldest};
      end
      if ((prefix_q[s] > best_len_d) ||
          ((prefix_q[s] == best_len_d) && (prefix_q[s] != '0) &&
           (rank[SLOT_W-1:0] > best_slot_d))) begin
        best_len_d  = prefix_q[s];
        best_slot_d = rank[SLOT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < DICT_DEPTH; s++) begin
        prefix_q[s] <= '0;
        wlen_q[s]   <= '0;
      end
      still_q     <= '1;
      best_len_q  <= '0;
      best_slot_q <= '0;
    end else begin
      for (int s = 0; s < DICT_DEPTH; s++) begin
        prefix_q[s] <= prefix_d[s];
        wlen_q[s]   <= wlen_d[s];
      end
      still_q     <= still_d;
      best_len_q  <= best_len_d;
      best_slot_q <= best_slot_d;
    end
  end

  assign best_len_o  = best_len_q;
  assign best_slot_o = best_slot_q;

endmodule

// ===== rtl/recent_string_prefix_delta.sv =====
// recent_string_prefix_delta: front coder of strings against the 8 most recent
// strings. On a byte beat the window row for that position is read from the
// window RAM, then all slots compare in parallel in the next cycle. Once the
// string is received (or an empty-flag beat closes it), the best-entry search
// runs, the header beat goes out, each stored byte is read from the string
// buffer and then written to the window (with a suffix beat when past the prefix),
// and a commit follows; an overlong string gets only its header and is dropped.
// The copy of the string into the window goes through the single string-buffer
// read port, one stored byte at a time. Depends on rspd_pkg and the assertion header.
`include "recent_string_prefix_delta_assert.svh"

module recent_string_prefix_delta (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Input stream
  input  logic                            s_tvalid_i,
  output logic                            s_tready_o,
  input  logic [rspd_pkg::BYTE_W-1:0]     s_tdata_i,   // [7:0] byte_in
  input  logic                            s_tlast_i,   // end_of_string
  input  logic                            s_tuser_i,   // [0] empty_string
  // Result stream
  output logic                            m_tvalid_o,
  input  logic                            m_tready_i,
  // [5:0] prefix_length, [8:6] entry_index, [9] matched, [17:10] suffix_byte,
  // [18] too_long, [23:19] zero
  output logic [rspd_pkg::OUT_DATA_W-1:0] m_tdata_o,
  output logic                            m_tlast_o,   // last_of_run
  output logic                            m_tuser_o,   // [0] item_kind
  // Configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rspd_pkg::APB_AW-1:0]     paddr,
  input  logic [rspd_pkg::APB_DW-1:0]     pwdata,
  output logic [rspd_pkg::APB_DW-1:0]     prdata,
  output logic                            pready
);
  import rspd_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,    // wait for a beat
    ST_CMP,     // window row ready: fold the byte into every lane
    ST_FIND,    // best-entry search settles into its register
    ST_HDR,     // emit the header beat
    ST_RD,      // read one stored byte of the string
    ST_WR,      // copy it into the window, emit it if past the prefix
    ST_COMMIT,  // record the length, retire the oldest slot
    ST_FLUSH    // drop an overlong string
  } state_e;

  state_e state_q, state_d;

  logic [LEN_W-1:0]  len_q, len_d;
  logic              ovf_q, ovf_d;
  logic              eos_q, eos_d;
  logic [BYTE_W-1:0] byte_q, byte_d;
  logic [LEN_W-1:0]  plen_q, plen_d;
  logic [LEN_W-1:0]  pos_q, pos_d;
  logic [SLOT_W-1:0] oldest_q, oldest_d;

  // Output register
  logic              ov_q, ov_d;
  logic              okind_q, okind_d;
  logic [PLEN_W-1:0] oplen_q, oplen_d;
  logic [IDX_W-1:0]  oidx_q, oidx_d;
  logic              omatch_q, omatch_d;
  logic [BYTE_W-1:0] obyte_q, obyte_d;
  logic              olast_q, olast_d;
  logic              otl_q, otl_d;

  logic [MIN_W-1:0]  min_match;
  logic [CAP_W-1:0]  match_cap;

  logic                              win_re, win_we;
  logic [DICT_DEPTH-1:0][BYTE_W-1:0] win_row;
  logic                              ib_we, ib_re;
  logic [BYTE_W-1:0]                 ib_rdata;

  match_ctrl_t       mctl;
  logic [LEN_W-1:0]  best_len;
  logic [SLOT_W-1:0] best_slot;

  logic              in_acc;
  logic              out_free;
  logic              suffix;
  logic [LEN_W-1:0]  hdr_plen;
  logic [SLOT_W-1:0] hdr_slot;

  rspd_apb_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .min_match_o (min_match),
    .match_cap_o (match_cap)
  );

  // Reads happen only on byte beats and writes only during the copy, so the
  // two never touch the same row in overlapping cycles.
  rspd_window_ram u_window (
    .clk_i   (clk_i),
    .re_i    (win_re),
    .raddr_i (len_q[POS_W-1:0]),
    .rdata_o (win_row),
    .we_i    (win_we),
    .waddr_i (pos_q[POS_W-1:0]),
    .wlane_i (oldest_q),
    .wdata_i (ib_rdata)
  );

  rspd_string_buf u_strbuf (
    .clk_i   (clk_i),
    .we_i    (ib_we),
    .waddr_i (len_q[POS_W-1:0]),
    .wdata_i (s_tdata_i),
    .re_i    (ib_re),
    .raddr_i (pos_q[POS_W-1:0]),
    .rdata_o (ib_rdata)
  );

  rspd_match_lanes u_lanes (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (mctl),
    .match_cap_i (match_cap),
    .row_i       (win_row),
    .best_len_o  (best_len),
    .best_slot_o (best_slot)
  );

  assign s_tready_o = (state_q == ST_IDLE);
  assign in_acc     = s_tvalid_i && s_tready_o;
  assign out_free   = !ov_q || m_tready_i;
  assign suffix     = (pos_q >= plen_q);

  // Header: drop prefixes below min_match, never claim more than was received.
  always_comb begin
    if (CAP_W'(best_len) < CAP_W'(min_match)) begin
      hdr_plen = '0;
    end else begin
      hdr_plen = best_len;
    end
    if (hdr_plen > len_q) begin
      hdr_plen = len_q;
    end
    hdr_slot = (hdr_plen == '0) ? '0 : best_slot;
  end

  always_comb begin
    state_d  = state_q;
    len_d    = len_q;
    ovf_d    = ovf_q;
    eos_d    = eos_q;
    byte_d   = byte_q;
    plen_d   = plen_q;
    pos_d    = pos_q;
    oldest_d = oldest_q;

    ov_d     = ov_q && !m_tready_i;
    okind_d  = okind_q;
    oplen_d  = oplen_q;
    oidx_d   = oidx_q;
    omatch_d = omatch_q;
    obyte_d  = obyte_q;
    olast_d  = olast_q;
    otl_d    = otl_q;

    mctl          = '0;
    mctl.byte_val = byte_q;
    mctl.pos      = len_q;
    mctl.oldest   = oldest_q;

    win_re = 1'b0;
    win_we = 1'b0;
    ib_we  = 1'b0;
    ib_re  = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          eos_d = s_tlast_i;
          if (!s_tuser_i && !ovf_q && (len_q < LEN_W'(MAX_LEN))) begin
            // Store the byte and fetch the window row at its position.
            win_re  = 1'b1;
            ib_we   = 1'b1;
            byte_d  = s_tdata_i;
            state_d = ST_CMP;
          end else begin
            if (!s_tuser_i) begin
              ovf_d = 1'b1;
            end
            if (s_tlast_i) begin
              state_d = ST_FIND;
            end
          end
        end
      end
      ST_CMP: begin
        mctl.step = 1'b1;
        len_d     = len_q + LEN_W'(1);
        state_d   = eos_q ? ST_FIND : ST_IDLE;
      end
      ST_FIND: begin
        state_d = ST_HDR;
      end
      ST_HDR: begin
        if (out_free) begin
          ov_d    = 1'b1;
          okind_d = KIND_HEADER;
          obyte_d = '0;
          if (ovf_q) begin
            oplen_d  = '0;
            oidx_d   = '0;
            omatch_d = 1'b0;
            olast_d  = 1'b1;
            otl_d    = 1'b1;
            state_d  = ST_FLUSH;
          end else begin
            oplen_d  = PLEN_W'(hdr_plen);
            oidx_d   = IDX_W'(hdr_slot);
            omatch_d = (hdr_plen != '0);
            olast_d  = (hdr_plen >= len_q);
            otl_d    = 1'b0;
            plen_d   = hdr_plen;
            pos_d    = '0;
            state_d  = (len_q == '0) ? ST_COMMIT : ST_RD;
          end
        end
      end
      ST_RD: begin
        ib_re   = 1'b1;
        state_d = ST_WR;
      end
      ST_WR: begin
        // Hold the byte until the result register frees up if it is a suffix.
        if (!suffix || out_free) begin
          win_we = 1'b1;
          if (suffix) begin
            ov_d     = 1'b1;
            okind_d  = KIND_SUFFIX;
            oplen_d  = '0;
            oidx_d   = '0;
            omatch_d = 1'b0;
            obyte_d  = ib_rdata;
            olast_d  = ((pos_q + LEN_W'(1)) == len_q);
            otl_d    = 1'b0;
          end
          pos_d   = pos_q + LEN_W'(1);
          state_d = ((pos_q + LEN_W'(1)) == len_q) ? ST_COMMIT : ST_RD;
        end
      end
      ST_COMMIT: begin
        mctl.commit = 1'b1;
        mctl.clear  = 1'b1;
        oldest_d    = (oldest_q == SLOT_W'(DICT_DEPTH - 1)) ? '0 : oldest_q + SLOT_W'(1);
        len_d       = '0;
        ovf_d       = 1'b0;
        state_d     = ST_IDLE;
      end
      ST_FLUSH: begin
        mctl.clear = 1'b1;
        len_d      = '0;
        ovf_d      = 1'b0;
        state_d    = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      len_q    <= '0;
      ovf_q    <= 1'b0;
      eos_q    <= 1'b0;
      byte_q   <= '0;
      plen_q   <= '0;
      pos_q    <= '0;
      oldest_q <= '0;
      ov_q     <= 1'b0;
      okind_q  <= KIND_HEADER;
      oplen_q  <= '0;
      oidx_q   <= '0;
      omatch_q <= 1'b0;
      obyte_q  <= '0;
      olast_q  <= 1'b0;
      otl_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      len_q    <= len_d;
      ovf_q    <= ovf_d;
      eos_q    <= eos_d;
      byte_q   <= byte_d;
      plen_q   <= plen_d;
      pos_q    <= pos_d;
      oldest_q <= oldest_d;
      ov_q     <= ov_d;
      okind_q  <= okind_d;
      oplen_q  <= oplen_d;
      oidx_q   <= oidx_d;
      omatch_q <= omatch_d;
      obyte_q  <= obyte_d;
      olast_q  <= olast_d;
      otl_q    <= otl_d;
    end
  end

  assign m_tvalid_o = ov_q;
  assign m_tuser_o  = okind_q;
  assign m_tlast_o  = olast_q;
  assign m_tdata_o  = {{(OUT_DATA_W - PLEN_W - IDX_W - BYTE_W - 2){1'b0}},
                       otl_q, obyte_q, omatch_q, oidx_q, oplen_q};

  // A window read is always followed by the lane compare.
  `RSPD_ASSERT(a_read_then_cmp, clk_i, rst_ni, win_re |=> (state_q == ST_CMP), "window read not followed by compare")
  // The receive count never passes the buffer size.
  `RSPD_ASSERT(a_len_bound, clk_i, rst_ni, (len_q <= LEN_W'(MAX_LEN)), "string length past buffer size")
  // The window only ages on a commit.
  `RSPD_ASSERT(a_oldest_commit, clk_i, rst_ni, (state_q != ST_COMMIT) |=> $stable(oldest_q), "oldest slot moved outside commit")
  // A header flags a match exactly when it carries a nonzero prefix.
  `RSPD_ASSERT(a_hdr_match, clk_i, rst_ni, (ov_q && (okind_q == KIND_HEADER)) |-> (omatch_q == (oplen_q != '0)), "header match flag disagrees with prefix length")
  // A dropped-string header is a lone final beat with no prefix.
  `RSPD_ASSERT(a_tl_fields, clk_i, rst_ni, (ov_q && otl_q) |-> ((oplen_q == '0) && olast_q && !omatch_q), "overlong header carries match data")

endmodule
